[design/teq_pkg.sv]
// shared constants and types for the timed event queue
`default_nettype none
package teq_pkg;
    localparam int unsigned DEPTH_DEF   = 16;
    localparam logic [31:0] ADVANCE_RST = 32'd300000000;
    localparam int unsigned DUE_W       = 50;
    localparam int unsigned ID_W        = 16;
    localparam int unsigned PRI_W       = 8;
    localparam int unsigned ENTRY_W     = DUE_W + ID_W + PRI_W;
    localparam logic [1:0]  MODE_POST   = 2'd0;
    localparam logic [1:0]  MODE_REMOVE = 2'd1;
    localparam logic [1:0]  MODE_POLL   = 2'd2;
    localparam logic [1:0]  MODE_CLEAR  = 2'd3;

    typedef struct packed {
        logic signed [DUE_W-1:0] due;
        logic [ID_W-1:0]         ident;
        logic signed [PRI_W-1:0] prio;
    } entry_t;
endpackage
`default_nettype wire

[design/teq_ram.sv]
// generic single-port-write ram with registered read
`default_nettype none
module teq_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire                     aclk,
    input  wire                     we,
    input  wire [$clog2(DEPTH)-1:0] waddr,
    input  wire [WIDTH-1:0]         wdata,
    input  wire [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]        rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[design/timed_event_queue_core.sv]
// top level of the timed event queue: sorted list in one ram, walked by a sequencer
//
//  channel | dir | handshake            | payload
//  s_      | in  | s_tvalid / s_tready  | mode, now_time, msg_id, delay, priority_req
//  m_      | out | m_tvalid / m_tready  | status, dispatched, out_msg_id, out_priority,
//          |     |                      | removed_any, became_head, occupancy
//  cfg     | in  | cfg_we               | urgent_advance
//
// a new word is taken only while idle; the ram has one read and one write port
// and a registered read, so the walk visits the entries in turn
// post: shift walk from the tail; remove and poll: compacting walk from the head;
// clear and a dropped post: no walk
// the result is loaded into an output register and the next word is taken right
// after; a result still waiting there holds the block in its last state
// aresetn clears the count and control; ram contents need no reset
`default_nettype none
module timed_event_queue_core
    import teq_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = DEPTH_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_we,
    input  wire  [31:0] cfg_wdata,
    input  wire         s_tvalid,
    output logic        s_tready,
    // [1:0] mode, [49:2] now_time, [65:50] msg_id, [106:66] delay,
    // [114:107] priority_req, zero fill to 120
    input  wire  [119:0] s_tdata,
    output logic        m_tvalid,
    input  wire         m_tready,
    // [0] status, [1] dispatched, [17:2] out_msg_id, [25:18] out_priority,
    // [26] removed_any, [27] became_head, [32:28] occupancy, zero fill to 40
    output logic [39:0] m_tdata
);
    localparam int unsigned AW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RUN  = 3'd1;
    localparam logic [2:0] ST_PRE  = 3'd2;
    localparam logic [2:0] ST_STEP = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [31:0] adv_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [1:0]  mode_reg;
    logic signed [48:0] now_reg;
    logic [ID_W-1:0] id_reg;
    logic signed [PRI_W-1:0] pri_reg;
    logic signed [DUE_W-1:0] due_reg;
    logic [CW-1:0] rd_reg, rd_next;   // read cursor
    logic [CW-1:0] wr_reg, wr_next;   // write cursor
    logic        flag_reg, flag_next; // removed / dispatched
    logic [ID_W-1:0] oid_reg, oid_next;
    logic [PRI_W-1:0] opri_reg, opri_next;
    logic        st_reg, st_next, head_reg, head_next;
    logic [39:0] out_reg;
    logic        ovalid_reg;

    logic        we;
    logic [AW-1:0] waddr, raddr;
    entry_t      wdata, rdata;
    logic [ENTRY_W-1:0] rdata_raw;

    teq_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata_raw)
    );
    assign rdata = entry_t'(rdata_raw);

    wire s_acc = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = out_reg;

    // due time for a post: now + max(delay,0), less the advance if urgent
    logic signed [40:0] dly_in;
    logic signed [PRI_W-1:0] pri_in;
    logic signed [DUE_W-1:0] due_in;
    always_comb begin
        dly_in = $signed(s_tdata[106:66]);
        pri_in = $signed(s_tdata[114:107]);
        due_in = $signed({2'b00, s_tdata[49:2]})
               + (dly_in > 0 ? DUE_W'(dly_in) : '0);
        if (pri_in < 0) begin
            due_in = due_in - $signed({18'd0, adv_reg});
        end
    end

    // rdata is the entry at rd_reg in a post walk, at rd_reg-1 in remove and poll (read issued last cycle)
    logic later;
    assign later = (rdata.due > due_reg) ||
                   (rdata.due == due_reg && rdata.prio < pri_reg);

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        rd_next = rd_reg;
        wr_next = wr_reg;
        flag_next = flag_reg;
        oid_next = oid_reg;
        opri_next = opri_reg;
        st_next = st_reg;
        head_next = head_reg;
        we = 1'b0;
        waddr = wr_reg[AW-1:0];
        wdata = rdata;
        raddr = rd_reg[AW-1:0];
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    flag_next = 1'b0; oid_next = '0; opri_next = '0;
                    st_next = 1'b0; head_next = 1'b0;
                    state_next = ST_RUN;
                    case (s_tdata[1:0])
                        MODE_POST: begin
                            if (count_reg >= CW'(QUEUE_DEPTH)) begin
                                st_next = 1'b1;
                                state_next = ST_OUT;
                            end
                            // walk from the tail: read count-1, write count
                            rd_next = count_reg;
                            wr_next = count_reg;
                            if (count_reg == '0) state_next = ST_STEP;
                            else state_next = ST_PRE;
                            if (count_reg >= CW'(QUEUE_DEPTH)) state_next = ST_OUT;
                            raddr = AW'(count_reg - 1'b1);
                        end
                        MODE_CLEAR: begin
                            count_next = '0;
                            state_next = ST_OUT;
                        end
                        default: begin
                            rd_next = '0;
                            wr_next = '0;
                            raddr = '0;
                            state_next = (count_reg == '0) ? ST_OUT : ST_PRE;
                        end
                    endcase
                end
            end
            ST_PRE: begin
                // repeat the first read so data and cursor line up
                if (mode_reg == MODE_POST) begin
                    raddr = AW'(rd_reg - 1'b1);
                    rd_next = rd_reg - 1'b1;
                end else begin
                    rd_next = rd_reg + 1'b1;
                end
                state_next = ST_RUN;
            end
            ST_RUN: begin
                if (mode_reg == MODE_POST) begin
                    // rdata = entry rd_reg; shift up if later than new event
                    if (later) begin
                        we = 1'b1;
                        waddr = wr_reg[AW-1:0];
                        wr_next = wr_reg - 1'b1;
                        if (rd_reg == '0) begin
                            state_next = ST_STEP;
                        end else begin
                            raddr = AW'(rd_reg - 1'b1);
                            rd_next = rd_reg - 1'b1;
                        end
                    end else begin
                        state_next = ST_STEP;
                    end
                end else begin
                    // rdata = entry rd_reg-1
                    if (mode_reg == MODE_REMOVE) begin
                        if (rdata.ident == id_reg) begin
                            flag_next = 1'b1;
                        end else begin
                            we = 1'b1;
                            wr_next = wr_reg + 1'b1;
                        end
                    end else if (rd_reg == CW'(1)) begin
                        // poll: look at the head
                        if (rdata.due <= $signed({1'b0, now_reg})) begin
                            flag_next = 1'b1;
                            oid_next = rdata.ident;
                            opri_next = rdata.prio;
                        end else begin
                            state_next = ST_OUT;
                        end
                    end else begin
                        we = 1'b1;
                        wr_next = wr_reg + 1'b1;
                    end
                    if (rd_reg == count_reg) begin
                        state_next = ST_OUT;
                        if (mode_reg == MODE_REMOVE) begin
                            count_next = (rdata.ident == id_reg) ? wr_reg : wr_reg + 1'b1;
                        end else if (flag_next) begin
                            count_next = count_reg - 1'b1;
                        end
                    end else begin
                        raddr = rd_reg[AW-1:0];
                        rd_next = rd_reg + 1'b1;
                    end
                end
            end
            ST_STEP: begin
                // place the new event at wr_reg
                we = 1'b1;
                waddr = wr_reg[AW-1:0];
                wdata.due = due_reg;
                wdata.ident = id_reg;
                wdata.prio = pri_reg;
                head_next = (wr_reg == '0);
                count_next = count_reg + 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!ovalid_reg || m_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            adv_reg <= ADVANCE_RST;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_we) adv_reg <= cfg_wdata;
            if (state_reg == ST_OUT && state_next == ST_IDLE) begin
                ovalid_reg <= 1'b1;
            end else if (m_tready) begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_reg <= rd_next;
        wr_reg <= wr_next;
        flag_reg <= flag_next;
        oid_reg <= oid_next;
        opri_reg <= opri_next;
        st_reg <= st_next;
        head_reg <= head_next;
        if (s_acc) begin
            mode_reg <= s_tdata[1:0];
            now_reg  <= $signed({1'b0, s_tdata[49:2]});
            id_reg   <= s_tdata[65:50];
            pri_reg  <= pri_in;
            due_reg  <= due_in;
        end
        if (state_reg == ST_OUT && state_next == ST_IDLE) begin
            out_reg <= {7'd0, 5'(count_reg), head_reg,
                        (mode_reg == MODE_REMOVE) && flag_reg,
                        opri_reg, oid_reg,
                        (mode_reg == MODE_POLL) && flag_reg, st_reg};
        end
    end

    // the count never exceeds the depth
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(QUEUE_DEPTH)) else $error("count overflow");
    // no new word while busy
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_tready) else $error("ready while busy");
    // a clear leaves the list empty
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_tdata[1:0] == MODE_CLEAR) |=> (count_reg == '0))
        else $error("clear failed");
endmodule
`default_nettype wire

[tb/tb_timed_event_queue_core.sv]
// self-checking testbench for the timed event queue core
`default_nettype none
module tb_timed_event_queue_core
    import teq_pkg::*;
();

    localparam int unsigned DEPTH = DEPTH_DEF;

    // lowest field in the lowest bits, as on s_tdata
    typedef struct packed {
        logic signed [7:0]  priority_req;
        logic signed [40:0] delay;
        logic [15:0]        msg_id;
        logic [47:0]        now_time;
        logic [1:0]         mode;
    } cmd_t;

    typedef struct packed {
        logic [4:0]        occupancy;
        logic              became_head;
        logic              removed_any;
        logic signed [7:0] out_priority;
        logic [15:0]       out_msg_id;
        logic              dispatched;
        logic              status;
    } resp_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_we = 1'b0;
    logic [31:0]  cfg_wdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [119:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [39:0]  m_tdata;

    timed_event_queue_core dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #6 aclk = ~aclk;

    // shadow of the event list
    logic signed [49:0] q_due [DEPTH];
    logic [15:0]        q_id  [DEPTH];
    logic signed [7:0]  q_pri [DEPTH];
    int unsigned        q_cnt;
    logic [31:0]        advance;

    cmd_t   pending_cmds [$];
    resp_t  expected_resps [$];
    int     errors = 0;

    function automatic resp_t queue_apply(cmd_t c);
        resp_t r;
        logic signed [49:0] due;
        int unsigned pos, j;
        r = '0;
        case (c.mode)
            MODE_POST: begin
                if (q_cnt >= DEPTH) begin
                    r.status = 1'b1;
                end else begin
                    due = $signed({2'b00, c.now_time});
                    if (c.delay > 0) due = due + 50'(c.delay);
                    if (c.priority_req < 0) due = due - $signed({18'd0, advance});
                    pos = 0;
                    while (pos < q_cnt && (q_due[pos] < due ||
                           (q_due[pos] == due && q_pri[pos] >= c.priority_req)))
                        pos++;
                    for (int i = q_cnt; i > pos; i--) begin
                        q_due[i] = q_due[i-1]; q_id[i] = q_id[i-1]; q_pri[i] = q_pri[i-1];
                    end
                    q_due[pos] = due; q_id[pos] = c.msg_id; q_pri[pos] = c.priority_req;
                    q_cnt++;
                    r.became_head = (pos == 0);
                end
            end
            MODE_REMOVE: begin
                j = 0;
                for (int i = 0; i < q_cnt; i++) begin
                    if (q_id[i] == c.msg_id) begin
                        r.removed_any = 1'b1;
                    end else begin
                        q_due[j] = q_due[i]; q_id[j] = q_id[i]; q_pri[j] = q_pri[i];
                        j++;
                    end
                end
                q_cnt = j;
            end
            MODE_POLL: begin
                if (q_cnt > 0 && q_due[0] <= $signed({2'b00, c.now_time})) begin
                    r.dispatched = 1'b1;
                    r.out_msg_id = q_id[0];
                    r.out_priority = q_pri[0];
                    for (int i = 1; i < q_cnt; i++) begin
                        q_due[i-1] = q_due[i]; q_id[i-1] = q_id[i]; q_pri[i-1] = q_pri[i];
                    end
                    q_cnt--;
                end
            end
            default: q_cnt = 0;
        endcase
        r.occupancy = 5'(q_cnt);
        return r;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // input acceptance as seen at the rising edge
    logic s_fire = 1'b0;
    always @(posedge aclk) begin
        s_fire <= aresetn && s_tvalid && s_tready;
    end

    // driver
    int s_gap = 0;
    int m_gap = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_fire) begin
                expected_resps.push_back(queue_apply(cmd_t'(s_tdata[114:0])));
            end
            if (!s_tvalid || s_fire) begin
                if (s_gap > 0) begin
                    s_gap <= s_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    s_tdata <= {5'd0, pending_cmds[0]};
                    pending_cmds.delete(0);
                    s_tvalid <= 1'b1;
                    s_gap <= gap_len();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            if (m_gap > 0) begin
                m_gap <= m_gap - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                m_gap <= gap_len();
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        resp_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = resp_t'(m_tdata[32:0]);
            if (expected_resps.size() == 0) begin
                $error("result with nothing expected: %h", m_tdata);
                errors++;
            end else begin
                want = expected_resps[0];
                expected_resps.delete(0);
                if (got.status !== want.status) begin
                    $error("status exp %0d got %0d", want.status, got.status); errors++;
                end
                if (got.dispatched !== want.dispatched) begin
                    $error("dispatched exp %0d got %0d", want.dispatched, got.dispatched);
                    errors++;
                end
                if (got.out_msg_id !== want.out_msg_id) begin
                    $error("out_msg_id exp %h got %h", want.out_msg_id, got.out_msg_id);
                    errors++;
                end
                if (got.out_priority !== want.out_priority) begin
                    $error("out_priority exp %0d got %0d", want.out_priority, got.out_priority);
                    errors++;
                end
                if (got.removed_any !== want.removed_any) begin
                    $error("removed_any exp %0d got %0d", want.removed_any, got.removed_any);
                    errors++;
                end
                if (got.became_head !== want.became_head) begin
                    $error("became_head exp %0d got %0d", want.became_head, got.became_head);
                    errors++;
                end
                if (got.occupancy !== want.occupancy) begin
                    $error("occupancy exp %0d got %0d", want.occupancy, got.occupancy);
                    errors++;
                end
            end
        end
    end

    function automatic cmd_t make_cmd(logic [1:0] m, logic [47:0] t, logic [15:0] id,
                                      logic signed [40:0] d, logic signed [7:0] p);
        cmd_t c;
        c.mode = m; c.now_time = t; c.msg_id = id; c.delay = d; c.priority_req = p;
        return c;
    endfunction

    task automatic wait_idle();
        while (pending_cmds.size() > 0 || s_tvalid || expected_resps.size() > 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_advance(logic [31:0] v);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        advance = v;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // random content around a moving clock; ids from a small pool so removes hit
    function automatic cmd_t rand_cmd(logic [47:0] base);
        cmd_t c;
        int p;
        p = $urandom_range(0, 99);
        c.now_time = base + 48'($urandom_range(0, 2000));
        if ($urandom_range(0, 19) == 0) c.now_time = 48'({$urandom, $urandom});
        c.msg_id = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 23));
        c.delay = ($urandom_range(0, 9) == 0) ? 41'({$urandom, $urandom})
                                             : 41'($signed($urandom_range(0, 3000)) - 500);
        c.priority_req = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                    : 8'($urandom_range(0, 6)) - 8'sd2;
        if (p < 50) c.mode = MODE_POST;
        else if (p < 62) c.mode = MODE_REMOVE;
        else if (p < 97) c.mode = MODE_POLL;
        else c.mode = MODE_CLEAR;
        return c;
    endfunction

    initial begin
        logic [31:0] settings [4];
        logic [47:0] base;
        q_cnt = 0;
        advance = ADVANCE_RST;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, each mode, full queue, empty and not-due polls
        pending_cmds.push_back(make_cmd(MODE_POLL, 48'd0, 16'd0, 41'sd0, 8'sd0));
        pending_cmds.push_back(make_cmd(MODE_POST, 48'hFFFF_FFFF_FFFF, 16'hFFFF,
                                        41'h0FF_FFFF_FFFF, 8'sd127));
        pending_cmds.push_back(make_cmd(MODE_POST, 48'd0, 16'd1, -41'sd1, -8'sd128));
        pending_cmds.push_back(make_cmd(MODE_POST, 48'd0, 16'd2, 41'h100_0000_0000, 8'sd5));
        pending_cmds.push_back(make_cmd(MODE_POST, 48'd0, 16'd3, 41'sd0, 8'sd5));
        pending_cmds.push_back(make_cmd(MODE_POLL, 48'd0, 16'd0, 41'sd0, 8'sd0));
        pending_cmds.push_back(make_cmd(MODE_POLL, 48'd0, 16'd0, 41'sd0, 8'sd0));
        pending_cmds.push_back(make_cmd(MODE_REMOVE, 48'd0, 16'hFFFF, 41'sd0, 8'sd0));
        pending_cmds.push_back(make_cmd(MODE_REMOVE, 48'd0, 16'h1234, 41'sd0, 8'sd0));
        for (int i = 0; i < 17; i++)
            pending_cmds.push_back(make_cmd(MODE_POST, 48'd100, 16'(i), 41'sd10, 8'(i % 3)));
        pending_cmds.push_back(make_cmd(MODE_POLL, 48'd50, 16'd0, 41'sd0, 8'sd0));
        pending_cmds.push_back(make_cmd(MODE_CLEAR, 48'd0, 16'd0, 41'sd0, 8'sd0));
        wait_idle();

        settings[0] = 32'd0; settings[1] = 32'hFFFF_FFFF;
        settings[2] = 32'd700; settings[3] = ADVANCE_RST;
        base = 48'd5_000_000_000;
        for (int s = 0; s < 4; s++) begin
            write_advance(settings[s]);
            for (int n = 0; n < 325; n++) begin
                pending_cmds.push_back(rand_cmd(base));
                base = base + 48'($urandom_range(0, 60));
            end
            wait_idle();
        end

        if (errors == 0) begin
            $display("timed_event_queue_core: match");
        end else begin
            $display("timed_event_queue_core: mismatch");
        end
        $finish;
    end

    initial begin
        #(12 * 2000000);
        $display("timed_event_queue_core: mismatch");
        $finish;
    end
endmodule
`default_nettype wire
